// ===== rtl/core/segment_offset_locator_defines.svh =====
// ---------------------------------------------------------------------------
// Segment offset locator assertion macros
// Shared checking macros for the segment offset locator RTL.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_OFFSET_LOCATOR_DEFINES_SVH
`define SEGMENT_OFFSET_LOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property that is ignored while reset is held.
`define SOL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that must also hold during reset.
`define SOL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SOL_ASSERT(lbl, clk, rst, prop, msg)
`define SOL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/sol_pkg.sv =====
// ---------------------------------------------------------------------------
// Segment offset locator package
// Word types, mode and status codes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package sol_pkg;

  localparam int unsigned TOTAL_W = 42;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SIZE_W-1:0]  segment_size;
    logic [TOTAL_W-1:0] query_offset;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] segment_index;
    logic [SIZE_W-1:0]  local_offset;
    logic [STAT_W-1:0]  status;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_WALK
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/sol_table.sv =====
// ---------------------------------------------------------------------------
// Prefix sum table
// One write port and one registered read port over the running sums.
// ---------------------------------------------------------------------------
`default_nettype none

module sol_table #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire                             clk,
  input  wire sol_pkg::tbl_ctrl_t         ctrl,
  input  wire  [ADDR_W-1:0]               wr_addr,
  input  wire  [sol_pkg::TOTAL_W-1:0]     wr_data,
  input  wire  [ADDR_W-1:0]               rd_addr,
  output logic [sol_pkg::TOTAL_W-1:0]     rd_data
);
  import sol_pkg::*;

  logic [TOTAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/segment_offset_locator.sv =====
// ---------------------------------------------------------------------------
// Segment offset locator
// Prefix-sum table of segment sizes with a forward-walking offset lookup.
// ---------------------------------------------------------------------------
// Clear and no-operation words end in the execute state; an append also
// ends there, and its result strobes on the cycle after the word is executed.
// A query passes through the execute state, a start state when the pointer
// is not at segment 1, and a walk state that steps over table entries;
// the single table read port advances the walk by one entry a cycle.
// An out-of-range query is answered from the execute state. The receiver cannot stall.
// Reset empties the table, sets the search pointer to 1 and clears the strobe.
`default_nettype none

`include "segment_offset_locator_defines.svh"

module segment_offset_locator #(
  parameter int unsigned MAX_SEGMENTS = 1024
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire sol_pkg::req_t  request,
  output logic                busy,
  output logic                done,
  output sol_pkg::rsp_t       result
);
  import sol_pkg::*;

  // Counter and pointer hold 0..MAX_SEGMENTS; table addresses 0..MAX_SEGMENTS-1.
  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  // Sequencer state and the latched command word.
  state_t             state, state_next;
  req_t               req;

  // Architectural state: entry count, total of all sizes, and the search
  // pointer, which names the segment of the last hit (1-based), or 1 after reset or a clear.
  logic [CNT_W-1:0]   count, count_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic [CNT_W-1:0]   ptr, ptr_next;

  // Prefix sum at the segment before the pointer, i.e. where it starts.
  logic [TOTAL_W-1:0] seg_start, seg_start_next;

  // Result register and its load strobe.
  rsp_t               rsp_next;
  logic               rsp_load;

  // Table access.
  tbl_ctrl_t          tbl_ctrl;
  logic [ADDR_W-1:0]  rd_addr;
  logic [TOTAL_W-1:0] rd_data;

  // Shared compare unit: the query offset against either the total (range
  // check) or the entry just read from the table.
  logic [TOTAL_W-1:0] cmp_b;
  logic               q_gt;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] local_full;
  logic               q_bad;
  logic               full;
  logic               walk_more;
  logic [CNT_W-1:0]   ptr_fix;

  assign busy = (state != S_IDLE);

  sol_table #(
    .DEPTH  (MAX_SEGMENTS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .ctrl    (tbl_ctrl),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (sum[TOTAL_W-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Conditions shared by the next-state and the control logic.
  always_comb begin
    cmp_b      = (state == S_EXEC) ? total : rd_data;
    q_gt       = (req.query_offset > cmp_b);
    sum        = {1'b0, total} + {{(TOTAL_W - SIZE_W + 1){1'b0}}, req.segment_size};
    local_full = req.query_offset - seg_start;
    q_bad      = (req.query_offset == '0) || q_gt;
    full       = (count >= CNT_MAX) || sum[TOTAL_W];
    walk_more  = (ptr < count) && q_gt;
    // A pointer left outside the filled part of the table restarts at 1.
    ptr_fix    = ((ptr == '0) || (ptr > count)) ? CNT_ONE : ptr;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req.mode == MODE_QUERY && !q_bad) begin
          state_next = (ptr_fix == CNT_ONE) ? S_WALK : S_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_START: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!walk_more) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and datapath next values.
  always_comb begin
    count_next     = count;
    total_next     = total;
    ptr_next       = ptr;
    seg_start_next = seg_start;
    rsp_next       = '0;
    rsp_load       = 1'b0;
    tbl_ctrl       = '0;
    rd_addr        = '0;
    unique case (state)
      S_IDLE: begin
      end
      S_EXEC: begin
        unique case (req.mode)
          MODE_CLEAR: begin
            count_next = '0;
            total_next = '0;
            ptr_next   = CNT_ONE;
          end
          MODE_APPEND: begin
            rsp_load = 1'b1;
            if (full) begin
              rsp_next.status = STATUS_FULL;
            end else begin
              tbl_ctrl.wr_en         = 1'b1;
              count_next             = count + CNT_ONE;
              total_next             = sum[TOTAL_W-1:0];
              rsp_next.segment_index = INDEX_W'(count + CNT_ONE);
              rsp_next.status        = STATUS_OK;
            end
          end
          MODE_QUERY: begin
            if (q_bad) begin
              rsp_load        = 1'b1;
              rsp_next.status = STATUS_RANGE;
            end else begin
              ptr_next = ptr_fix;
              if (ptr_fix == CNT_ONE) begin
                // Segment 1 starts at the implicit zero; fetch its end.
                seg_start_next = '0;
                tbl_ctrl.rd_en = 1'b1;
                rd_addr        = '0;
              end else begin
                // Fetch the end of the segment before the pointer.
                tbl_ctrl.rd_en = 1'b1;
                rd_addr        = ADDR_W'(ptr_fix - CNT_TWO);
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_START: begin
        tbl_ctrl.rd_en = 1'b1;
        if (q_gt) begin
          seg_start_next = rd_data;
          rd_addr        = ADDR_W'(ptr - CNT_ONE);
        end else begin
          // Offset lies at or before this segment's start: walk from 1.
          ptr_next       = CNT_ONE;
          seg_start_next = '0;
          rd_addr        = '0;
        end
      end
      S_WALK: begin
        if (walk_more) begin
          seg_start_next = rd_data;
          ptr_next       = ptr + CNT_ONE;
          tbl_ctrl.rd_en = 1'b1;
          rd_addr        = ptr[ADDR_W-1:0];
        end else begin
          rsp_load               = 1'b1;
          rsp_next.segment_index = INDEX_W'(ptr);
          rsp_next.local_offset  = local_full[SIZE_W-1:0];
          rsp_next.status        = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      ptr   <= CNT_ONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      total <= total_next;
      ptr   <= ptr_next;
      done  <= rsp_load;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req <= request;
    end
    seg_start <= seg_start_next;
    if (rsp_load) begin
      result <= rsp_next;
    end
  end

  // A result only follows a cycle in which a word was being worked on.
  `SOL_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "result strobe without work")
  // The table never holds more entries than it has room for; the count is
  // only meaningful once reset has been applied.
  `SOL_ASSERT_ALWAYS(a_count_bound, clk, (rst || (count <= CNT_MAX)), "segment count beyond capacity")
  // While walking, the pointer stays inside the filled part of the table.
  `SOL_ASSERT(a_walk_ptr, clk, rst, (state == S_WALK) |-> ((ptr != '0) && (ptr <= count)), "walk pointer outside table")
  // A query walk only runs when the table holds something.
  `SOL_ASSERT(a_walk_nonempty, clk, rst, (state == S_START || state == S_WALK) |-> (total != '0), "walk on empty total")

endmodule

`default_nettype wire
